/* design/i2c_mbs_pkg.sv */
package i2c_mbs_pkg;

  localparam int unsigned TickW    = 10;
  localparam int unsigned PhaseW   = 5;
  localparam int unsigned BitIdxW  = 3;
  localparam logic [TickW-1:0] PhaseTicksReset = 10'd4;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_byte;
    logic       ack_level;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [PhaseW-1:0] phase;
    logic [TickW-1:0]  ticks;
    logic [7:0]        shift_byte;
    logic              scl;
    logic              sda;
    logic              sda_en;
    logic              ack;
    logic [7:0]        read_result;
  } state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       rejected;
  } result_t;

  localparam state_t StateReset = '{
    cmd:         CMD_NONE,
    phase:       '0,
    ticks:       '0,
    shift_byte:  '0,
    scl:         1'b1,
    sda:         1'b1,
    sda_en:      1'b1,
    ack:         1'b1,
    read_result: '0
  };

  function automatic logic [PhaseW-1:0] phase_total(cmd_e cmd);
    logic [PhaseW-1:0] total;
    case (cmd)
      CMD_START: total = 5'd4;
      CMD_STOP:  total = 5'd3;
      CMD_WRITE: total = 5'd24;
      CMD_READ:  total = 5'd24;
      CMD_SACK:  total = 5'd3;
      CMD_RACK:  total = 5'd2;
      default:   total = 5'd0;
    endcase
    return total;
  endfunction

endpackage

/* design/i2c_mbs_step.sv */
module i2c_mbs_step
  import i2c_mbs_pkg::*;
(
  input  state_t           state_i,
  input  logic [TickW-1:0] phase_ticks_i,
  input  item_t            item_i,
  output state_t           state_o,
  output result_t          res_o
);

  always_comb begin
    state_t              s;
    logic [TickW-1:0]    limit;
    logic                is_cmd;
    logic                do_enter;
    logic                done;
    logic                rej;
    logic [PhaseW-1:0]   p;
    logic [8:0]          prod;
    logic [BitIdxW-1:0]  bit_idx;
    logic [1:0]          sub;
    logic [BitIdxW-1:0]  pos;

    s        = state_i;
    limit    = (phase_ticks_i == '0) ? TickW'(1) : phase_ticks_i;
    is_cmd   = (item_i.opcode >= 3'(CMD_START)) && (item_i.opcode <= 3'(CMD_RACK));
    do_enter = 1'b0;
    done     = 1'b0;
    rej      = 1'b0;

    if (s.cmd != CMD_NONE) begin
      rej     = is_cmd;
      s.ticks = s.ticks + TickW'(1);
      if (s.ticks >= limit) begin
        s.ticks = '0;
        s.phase = s.phase + PhaseW'(1);
        if (s.phase >= phase_total(s.cmd)) begin
          if (s.cmd == CMD_READ) begin
            s.sda_en      = 1'b1;
            s.read_result = s.shift_byte;
          end else if (s.cmd == CMD_RACK) begin
            s.scl    = 1'b0;
            s.sda_en = 1'b1;
          end
          s.cmd   = CMD_NONE;
          s.phase = '0;
          done    = 1'b1;
        end else begin
          do_enter = 1'b1;
        end
      end
    end else if (is_cmd) begin
      s.cmd   = cmd_e'(item_i.opcode);
      s.phase = '0;
      s.ticks = '0;
      if (s.cmd == CMD_WRITE) begin
        s.shift_byte = item_i.write_byte;
      end
      do_enter = 1'b1;
    end

    // Bit number and sub-phase of a byte phase; p/3 is p*11/32 for p below 24.
    p       = s.phase;
    prod    = 9'(p) * 9'd11;
    bit_idx = prod[7:5];
    sub     = 2'(p - 5'({2'b00, bit_idx} * 5'd3));
    pos     = 3'(3'd7 - bit_idx);

    if (do_enter) begin
      case (s.cmd)
        CMD_START: begin
          if (p == 5'd0) begin
            s.sda_en = 1'b1;
            s.sda    = 1'b1;
          end else if (p == 5'd1) begin
            s.scl = 1'b1;
          end else if (p == 5'd2) begin
            s.sda = 1'b0;
          end else begin
            s.scl = 1'b0;
          end
        end
        CMD_STOP: begin
          if (p == 5'd0) begin
            s.sda_en = 1'b1;
            s.sda    = 1'b0;
          end else if (p == 5'd1) begin
            s.scl = 1'b1;
          end else begin
            s.sda = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (sub == 2'd0) begin
            s.sda_en = 1'b1;
            s.sda    = s.shift_byte[pos];
          end else if (sub == 2'd1) begin
            s.scl = 1'b1;
          end else begin
            s.scl = 1'b0;
          end
        end
        CMD_READ: begin
          if (sub == 2'd0) begin
            if (p == 5'd0) begin
              s.sda_en     = 1'b0;
              s.sda        = 1'b1;
              s.shift_byte = '0;
            end
            s.scl = 1'b1;
          end else if (sub == 2'd1) begin
            if (item_i.sda_sample) begin
              s.shift_byte[pos] = 1'b1;
            end
          end else begin
            s.scl = 1'b0;
          end
        end
        CMD_SACK: begin
          if (p == 5'd0) begin
            s.sda_en = 1'b1;
            s.sda    = item_i.ack_level;
          end else if (p == 5'd1) begin
            s.scl = 1'b1;
          end else begin
            s.scl = 1'b0;
          end
        end
        CMD_RACK: begin
          if (p == 5'd0) begin
            s.sda    = 1'b1;
            s.sda_en = 1'b0;
            s.scl    = 1'b1;
          end else begin
            s.ack = item_i.sda_sample;
          end
        end
        default: begin
        end
      endcase
    end

    state_o         = s;
    res_o.scl_level = s.scl;
    res_o.sda_level = s.sda;
    res_o.sda_drive = s.sda_en;
    res_o.busy_res  = (s.cmd != CMD_NONE);
    res_o.done_res  = done;
    res_o.read_byte = s.read_result;
    res_o.ack_seen  = s.ack;
    res_o.rejected  = rej;
  end

endmodule

/* design/i2c_master_bit_sequencer.sv */
// I2C master bit engine. Every input beat is one tick of the bus timer and may carry a
// command (start, stop, write byte, read byte, send ACK, receive ACK); each bus phase holds
// its pin levels for phase_ticks ticks (zero counts as one), and every input beat yields
// exactly one result beat with the pin levels, busy, done, the last read byte, the last
// ACK level and a flag for a command dropped while busy. One beat is accepted per clock
// while the output is not stalled. A beat is held in the input register; the tick logic
// between it and the result register, which drives the outputs, computes its result and
// the next engine state, which is kept in a state register for the next beat.
// Write phase_ticks only while no beats are in flight.
module i2c_master_bit_sequencer
  import i2c_mbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TickW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       opcode_i,
  input  logic [7:0]       write_byte_i,
  input  logic             ack_level_i,
  input  logic             sda_sample_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             scl_level_o,
  output logic             sda_level_o,
  output logic             sda_drive_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [7:0]       read_byte_o,
  output logic             ack_seen_o,
  output logic             rejected_o
);

  logic [TickW-1:0] phase_ticks_q;
  logic             in_valid_q;
  item_t            item_q;
  state_t           state_q, state_d;
  logic             out_valid_q;
  result_t          res_q, res_d;
  logic             advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  i2c_mbs_step u_step (
    .state_i       (state_q),
    .phase_ticks_i (phase_ticks_q),
    .item_i        (item_q),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksReset;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.opcode     <= opcode_i;
      item_q.write_byte <= write_byte_i;
      item_q.ack_level  <= ack_level_i;
      item_q.sda_sample <= sda_sample_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = res_q.scl_level;
  assign sda_level_o = res_q.sda_level;
  assign sda_drive_o = res_q.sda_drive;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign read_byte_o = res_q.read_byte;
  assign ack_seen_o  = res_q.ack_seen;
  assign rejected_o  = res_q.rejected;

endmodule

/* bench/tb_i2c_master_bit_sequencer.sv */
`timescale 1ns / 1ps

module tb_i2c_master_bit_sequencer;
  import i2c_mbs_pkg::*;

  localparam logic [2:0] OpReserved    = 3'd7;
  localparam int         ResultLatency = 4;
  localparam int         StallLimit    = 4000;
  localparam int         LongHold      = 150;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TickW-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [2:0]       opcode_i;
  logic [7:0]       write_byte_i;
  logic             ack_level_i;
  logic             sda_sample_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             scl_level_o;
  logic             sda_level_o;
  logic             sda_drive_o;
  logic             busy_res_o;
  logic             done_res_o;
  logic [7:0]       read_byte_o;
  logic             ack_seen_o;
  logic             rejected_o;

  i2c_master_bit_sequencer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .write_byte_i (write_byte_i),
    .ack_level_i  (ack_level_i),
    .sda_sample_i (sda_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_level_o  (scl_level_o),
    .sda_level_o  (sda_level_o),
    .sda_drive_o  (sda_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_byte_o  (read_byte_o),
    .ack_seen_o   (ack_seen_o),
    .rejected_o   (rejected_o)
  );

  cmd_e             eng_cmd         = CMD_NONE;
  logic [PhaseW-1:0] eng_phase      = '0;
  logic [TickW-1:0] eng_ticks       = '0;
  logic [7:0]       eng_shift       = '0;
  logic             eng_scl         = 1'b1;
  logic             eng_sda         = 1'b1;
  logic             eng_sda_en      = 1'b1;
  logic             eng_ack         = 1'b1;
  logic [7:0]       eng_read        = '0;
  logic [TickW-1:0] eng_phase_ticks = PhaseTicksReset;

  result_t pending_pin_reports[$];
  result_t want_report;
  int      failures    = 0;
  int      beats_sent  = 0;
  int      stall_count = 0;
  int      rx_hold_req = 0;
  bit      tx_gaps     = 1'b1;
  bit      rx_stalls   = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [PhaseW-1:0] phase_count(input cmd_e c);
    case (c)
      CMD_START: return 5'd4;
      CMD_STOP:  return 5'd3;
      CMD_WRITE: return 5'd24;
      CMD_READ:  return 5'd24;
      CMD_SACK:  return 5'd3;
      CMD_RACK:  return 5'd2;
      default:   return 5'd0;
    endcase
  endfunction

  function automatic void enter_bus_phase(input logic ack_in, input logic sample);
    logic [4:0] sub;
    logic [2:0] bit_pos;
    sub     = 5'(eng_phase % 3);
    bit_pos = 3'(eng_phase / 3);
    case (eng_cmd)
      CMD_START: begin
        case (eng_phase)
          5'd0: begin
            eng_sda_en = 1'b1;
            eng_sda    = 1'b1;
          end
          5'd1: eng_scl = 1'b1;
          5'd2: eng_sda = 1'b0;
          default: eng_scl = 1'b0;
        endcase
      end
      CMD_STOP: begin
        case (eng_phase)
          5'd0: begin
            eng_sda_en = 1'b1;
            eng_sda    = 1'b0;
          end
          5'd1: eng_scl = 1'b1;
          default: eng_sda = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        if (sub == 0) begin
          eng_sda_en = 1'b1;
          eng_sda    = eng_shift[3'd7 - bit_pos];
        end else if (sub == 1) begin
          eng_scl = 1'b1;
        end else begin
          eng_scl = 1'b0;
        end
      end
      CMD_READ: begin
        if (sub == 0) begin
          if (eng_phase == 0) begin
            eng_sda_en = 1'b0;
            eng_sda    = 1'b1;
            eng_shift  = '0;
          end
          eng_scl = 1'b1;
        end else if (sub == 1) begin
          if (sample) eng_shift[3'd7 - bit_pos] = 1'b1;
        end else begin
          eng_scl = 1'b0;
        end
      end
      CMD_SACK: begin
        case (eng_phase)
          5'd0: begin
            eng_sda_en = 1'b1;
            eng_sda    = ack_in;
          end
          5'd1: eng_scl = 1'b1;
          default: eng_scl = 1'b0;
        endcase
      end
      CMD_RACK: begin
        if (eng_phase == 0) begin
          eng_sda    = 1'b1;
          eng_sda_en = 1'b0;
          eng_scl    = 1'b1;
        end else begin
          eng_ack = sample;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic result_t step_bus_engine(input item_t beat);
    result_t          r;
    logic [TickW-1:0] lim;
    logic             is_cmd;
    logic             done;
    logic             rej;
    lim    = (eng_phase_ticks == '0) ? TickW'(1) : eng_phase_ticks;
    is_cmd = beat.opcode != CMD_NONE && beat.opcode != OpReserved;
    done   = 1'b0;
    rej    = 1'b0;
    if (eng_cmd != CMD_NONE) begin
      rej       = is_cmd;
      eng_ticks = eng_ticks + TickW'(1);
      if (eng_ticks >= lim) begin
        eng_ticks = '0;
        eng_phase = eng_phase + PhaseW'(1);
        if (eng_phase >= phase_count(eng_cmd)) begin
          if (eng_cmd == CMD_READ) begin
            eng_sda_en = 1'b1;
            eng_read   = eng_shift;
          end else if (eng_cmd == CMD_RACK) begin
            eng_scl    = 1'b0;
            eng_sda_en = 1'b1;
          end
          eng_cmd   = CMD_NONE;
          eng_phase = '0;
          done      = 1'b1;
        end else begin
          enter_bus_phase(beat.ack_level, beat.sda_sample);
        end
      end
    end else if (is_cmd) begin
      eng_cmd   = cmd_e'(beat.opcode);
      eng_phase = '0;
      eng_ticks = '0;
      if (eng_cmd == CMD_WRITE) eng_shift = beat.write_byte;
      enter_bus_phase(beat.ack_level, beat.sda_sample);
    end
    r.scl_level = eng_scl;
    r.sda_level = eng_sda;
    r.sda_drive = eng_sda_en;
    r.busy_res  = eng_cmd != CMD_NONE;
    r.done_res  = done;
    r.read_byte = eng_read;
    r.ack_seen  = eng_ack;
    r.rejected  = rej;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", field, exp_v, act_v);
      failures++;
    end
  endtask

  // The output beat seen at a falling edge is taken at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_pin_reports.size() == 0) begin
        $error("Result beat arrived with no expected result pending.");
        failures++;
      end else begin
        want_report = pending_pin_reports.pop_front();
        check_field("scl_level", 8'(want_report.scl_level), 8'(scl_level_o));
        check_field("sda_level", 8'(want_report.sda_level), 8'(sda_level_o));
        check_field("sda_drive", 8'(want_report.sda_drive), 8'(sda_drive_o));
        check_field("busy_res", 8'(want_report.busy_res), 8'(busy_res_o));
        check_field("done_res", 8'(want_report.done_res), 8'(done_res_o));
        check_field("read_byte", want_report.read_byte, read_byte_o);
        check_field("ack_seen", 8'(want_report.ack_seen), 8'(ack_seen_o));
        check_field("rejected", 8'(want_report.rejected), 8'(rejected_o));
      end
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_req) @(posedge clk_i);
        rx_hold_req = 0;
        out_ready_i <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    while (stall_count < StallLimit) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_beat(input item_t beat);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= beat.opcode;
    write_byte_i <= beat.write_byte;
    ack_level_i  <= beat.ack_level;
    sda_sample_i <= beat.sda_sample;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pending_pin_reports.push_back(step_bus_engine(beat));
    beats_sent++;
  endtask

  task automatic send_op(input logic [2:0] op, input logic [7:0] wb, input logic ackl,
                         input logic smp);
    item_t beat;
    beat.opcode     = op;
    beat.write_byte = wb;
    beat.ack_level  = ackl;
    beat.sda_sample = smp;
    send_beat(beat);
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_pin_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_phase_ticks(input logic [TickW-1:0] value);
    drain_results();
    repeat (ResultLatency) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    eng_phase_ticks = value;
  endtask

  // Busy ticks carry, when noisy is set, an occasional command or reserved opcode that must be dropped.
  task automatic finish_command(input bit noisy);
    logic [2:0] op;
    while (eng_cmd != CMD_NONE) begin
      op = CMD_NONE;
      if (noisy && $urandom_range(0, 15) == 0) op = 3'($urandom_range(CMD_START, OpReserved));
      send_op(op, random_byte(), 1'($urandom), noisy ? 1'($urandom) : 1'b0);
    end
  endtask

  task automatic run_command(input cmd_e op);
    send_op(op, random_byte(), 1'($urandom), 1'($urandom));
    finish_command(1'b1);
  endtask

  task automatic run_transaction();
    int n_bytes;
    n_bytes = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) run_command(cmd_e'($urandom_range(CMD_START, CMD_RACK)));
    end else begin
      run_command(CMD_START);
      run_command(CMD_WRITE);
      run_command(CMD_RACK);
      repeat (n_bytes) begin
        if ($urandom_range(0, 1) == 0) begin
          run_command(CMD_WRITE);
          run_command(CMD_RACK);
        end else begin
          run_command(CMD_READ);
          run_command(CMD_SACK);
        end
      end
      if ($urandom_range(0, 7) != 0) run_command(CMD_STOP);
    end
    repeat ($urandom_range(0, 3)) begin
      send_op($urandom_range(0, 1) ? OpReserved : CMD_NONE, random_byte(), 1'($urandom),
              1'($urandom));
    end
  endtask

  task automatic run_bus_traffic(input int budget);
    int stop_at;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) run_transaction();
  endtask

  task automatic test_reset_state();
    send_op(CMD_NONE, 8'h00, 1'b0, 1'b0);
    send_op(OpReserved, 8'hFF, 1'b1, 1'b1);
    send_op(CMD_RACK, 8'h00, 1'b0, 1'b0);
    finish_command(1'b0);
  endtask

  task automatic test_directed_commands();
    set_phase_ticks('0);
    send_op(CMD_START, 8'h00, 1'b0, 1'b0);
    send_op(CMD_STOP, 8'hFF, 1'b1, 1'b1);
    send_op(OpReserved, 8'h00, 1'b0, 1'b0);
    finish_command(1'b0);
    send_op(CMD_SACK, 8'h00, 1'b0, 1'b0);
    finish_command(1'b0);
    send_op(CMD_SACK, 8'h00, 1'b1, 1'b0);
    finish_command(1'b0);
    send_op(CMD_STOP, 8'h00, 1'b0, 1'b0);
    finish_command(1'b0);
  endtask

  task automatic test_phase_length_extremes();
    set_phase_ticks(10'h3FF);
    send_op(CMD_START, 8'h00, 1'b0, 1'b0);
    repeat (30) send_op(CMD_NONE, random_byte(), 1'($urandom), 1'($urandom));
    set_phase_ticks(10'd1);
    finish_command(1'b1);
  endtask

  task automatic test_random_traffic();
    set_phase_ticks(10'd1);
    run_bus_traffic(300);
    set_phase_ticks(10'd2);
    run_bus_traffic(250);
    set_phase_ticks(10'd3);
    run_bus_traffic(200);
  endtask

  task automatic test_output_backpressure();
    tx_gaps = 1'b0;
    set_phase_ticks(10'd1);
    rx_hold_req = LongHold;
    run_bus_traffic(100);
    drain_results();
    tx_gaps = 1'b1;
    run_bus_traffic(100);
  endtask

  task automatic test_steady_stream();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    set_phase_ticks(10'd2);
    run_bus_traffic(300);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    opcode_i     <= CMD_NONE;
    write_byte_i <= '0;
    ack_level_i  <= 1'b0;
    sda_sample_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_commands();
    test_phase_length_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_steady_stream();
    drain_results();
    repeat (ResultLatency * 2) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
